/* design/sawtc_pkg.sv */
// Shared types, codes and helper functions of the set-associative write-through cache.
package sawtc_pkg;

    localparam int SETS_DEFAULT       = 8;
    localparam int WAYS_DEFAULT       = 128;
    localparam int LINE_BYTES_DEFAULT = 64;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_FILL  = 2'd3;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_FILL_REQ = 2'd1;
    localparam logic [1:0] KIND_MEM_WR   = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [2:0]  access_length;
        logic [31:0] write_data;
        logic [31:0] fill_data;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] read_data;
        logic [31:0] mem_address;
        logic [2:0]  mem_length;
        logic [31:0] mem_data;
    } rsp_item_t;

    typedef struct packed {
        logic scan_start;
        logic wr_en;
        logic wr_valid;
    } tag_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic free;
    } scan_stat_t;

    // Lengths above four bytes behave as four.
    function automatic logic [2:0] clamp_len(input logic [2:0] len);
        return (len > 3'd4) ? 3'd4 : len;
    endfunction

    function automatic logic [3:0] len_mask(input logic [2:0] len);
        logic [3:0] m;
        case (len)
            3'd0:    m = 4'b0000;
            3'd1:    m = 4'b0001;
            3'd2:    m = 4'b0011;
            3'd3:    m = 4'b0111;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

    // Four bytes starting at byte offset off of the little-endian pair {w1, w0}.
    function automatic logic [31:0] combine(input logic [31:0] w0, input logic [31:0] w1,
                                            input logic [1:0] off);
        logic [63:0] v;
        v = {w1, w0} >> {off, 3'b000};
        return v[31:0];
    endfunction

endpackage

/* design/sawtc_data_ram.sv */
// Single-port line data memory with registered read data.
module sawtc_data_ram #(
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          re,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* design/sawtc_tag_scan.sv */
// Tag and valid memory with the way-by-way compare unit that searches one set.
module sawtc_tag_scan #(
    parameter int SETS       = 8,
    parameter int WAYS       = 128,
    parameter int LINE_BYTES = 64,
    localparam int LW = $clog2(SETS * WAYS),
    localparam int WB = $clog2(WAYS),
    localparam int TW = 32 - $clog2(LINE_BYTES) - $clog2(SETS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sawtc_pkg::tag_cmd_t   cmd,
    input  logic [LW-1:0]         set_base,
    input  logic [TW-1:0]         scan_tag,
    input  logic [LW-1:0]         wr_line,
    input  logic [TW-1:0]         wr_tag,
    output sawtc_pkg::scan_stat_t stat,
    output logic [WB-1:0]         hit_way,
    output logic [WB-1:0]         free_way
);
    import sawtc_pkg::*;

    localparam int LINES = SETS * WAYS;

    logic [TW:0]   tag_mem [LINES];
    logic [TW:0]   q_reg;
    logic          busy_reg, busy_next;
    logic [WB:0]   iss_reg, iss_next;
    logic          chk_reg, chk_next;
    logic [WB-1:0] chk_way_reg, chk_way_next;
    logic          hit_reg, hit_next;
    logic [WB-1:0] hit_way_reg, hit_way_next;
    logic          free_reg, free_next;
    logic [WB-1:0] free_way_reg, free_way_next;
    logic          done_reg, done_next;
    logic          rd_en;
    logic [LW-1:0] rd_line;

    assign rd_en   = busy_reg && (iss_reg < (WB+1)'(WAYS)) && !cmd.scan_start;
    assign rd_line = set_base + LW'(iss_reg[WB-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            tag_mem[wr_line] <= {cmd.wr_valid, wr_tag};
        end
        else if (rd_en)
        begin
            q_reg <= tag_mem[rd_line];
        end
    end

    always_comb
    begin
        busy_next     = busy_reg;
        iss_next      = iss_reg;
        chk_next      = chk_reg;
        chk_way_next  = chk_way_reg;
        hit_next      = hit_reg;
        hit_way_next  = hit_way_reg;
        free_next     = free_reg;
        free_way_next = free_way_reg;
        done_next     = 1'b0;
        if (cmd.scan_start)
        begin
            busy_next = 1'b1;
            iss_next  = '0;
            chk_next  = 1'b0;
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (busy_reg)
        begin
            chk_next = rd_en;
            if (rd_en)
            begin
                iss_next     = iss_reg + 1'b1;
                chk_way_next = iss_reg[WB-1:0];
            end
            if (chk_reg)
            begin
                if (q_reg[TW] && (q_reg[TW-1:0] == scan_tag) && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_way_next = chk_way_reg;
                end
                if (!q_reg[TW] && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_way_next = chk_way_reg;
                end
                if (!rd_en)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            iss_reg      <= '0;
            chk_reg      <= 1'b0;
            chk_way_reg  <= '0;
            hit_reg      <= 1'b0;
            hit_way_reg  <= '0;
            free_reg     <= 1'b0;
            free_way_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            iss_reg      <= iss_next;
            chk_reg      <= chk_next;
            chk_way_reg  <= chk_way_next;
            hit_reg      <= hit_next;
            hit_way_reg  <= hit_way_next;
            free_reg     <= free_next;
            free_way_reg <= free_way_next;
            done_reg     <= done_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.hit  = hit_reg;
    assign stat.free = free_reg;
    assign hit_way   = hit_way_reg;
    assign free_way  = free_way_reg;
endmodule

/* design/set_assoc_write_through_cache.sv */
// Set-associative write-through cache: sequencer, request latch and response register.
// A word lookup walks the ways of one set through the shared tag comparator, and a hit
// then reads the word from the data memory. A read or write that spans two words looks
// up each word in turn and answers once.
// Each fill word is written alone; after the last word of a line the read resumes.
// After reset and on a flush the SETS * WAYS valid bits are cleared one a cycle, not ready.
module set_assoc_write_through_cache #(
    parameter int SETS       = sawtc_pkg::SETS_DEFAULT,
    parameter int WAYS       = sawtc_pkg::WAYS_DEFAULT,
    parameter int LINE_BYTES = sawtc_pkg::LINE_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sawtc_pkg::req_item_t req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output sawtc_pkg::rsp_item_t rsp
);
    import sawtc_pkg::*;

    localparam int OB    = $clog2(LINE_BYTES);
    localparam int WPL   = LINE_BYTES / 4;
    localparam int WDB   = $clog2(WPL);
    localparam int SLOG  = $clog2(SETS);
    localparam int LINES = SETS * WAYS;
    localparam int LW    = $clog2(LINES);
    localparam int WB    = $clog2(WAYS);
    localparam int TW    = 32 - OB - SLOG;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DDONE = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_FREAD = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]     state_reg, state_next;
    logic [1:0]     act_reg, act_next;
    logic [31:0]    addr_reg, addr_next;
    logic [2:0]     len_reg, len_next;
    logic [31:0]    wdata_reg, wdata_next;
    logic [31:0]    fdata_reg, fdata_next;
    logic [31:0]    pa_reg, pa_next;
    logic [2:0]     plen_reg, plen_next;
    logic           widx_reg, widx_next;
    logic [31:0]    fwb_reg, fwb_next;
    logic [OB-1:0]  seed_reg, seed_next;
    logic           fpend_reg, fpend_next;
    logic [WDB-1:0] fcnt_reg, fcnt_next;
    logic [WB-1:0]  fway_reg, fway_next;
    logic [LW-1:0]  clr_reg, clr_next;
    rsp_item_t      res_reg, res_next;
    logic           out_valid_reg, out_valid_next;
    rsp_item_t      out_reg, out_next;

    tag_cmd_t       tag_cmd;
    scan_stat_t     stat;
    logic [WB-1:0]  hit_way;
    logic [WB-1:0]  free_way;
    logic [LW-1:0]  tag_wr_line;

    logic           ram_re;
    logic           ram_we;
    logic [LW+WDB-1:0] ram_addr;
    logic [31:0]    ram_wdata;
    logic [31:0]    ram_q;

    logic [31:0]    base;
    logic [31:0]    cur_waddr;
    logic [LW-1:0]  set_base;
    logic [TW-1:0]  cur_tag;
    logic [WDB-1:0] cur_word;
    logic [LW-1:0]  hit_line;
    logic [LW-1:0]  fill_line;
    logic           rcross;
    logic           wcross;
    logic [2:0]     wlen;
    logic [63:0]    w_sh_data;
    logic [7:0]     w_sh_mask;
    logic [31:0]    w_bytes;
    logic [3:0]     w_mask;
    logic [31:0]    merged;
    logic [OB-1:0]  seed_new;
    logic [WB-1:0]  victim_way;
    logic           wr_more;
    rsp_item_t      res_write;

    // The word being looked up: the first or second word of the current access.
    assign base      = (act_reg == ACT_WRITE) ? addr_reg : pa_reg;
    assign cur_waddr = {base[31:2], 2'b00} + {29'd0, widx_reg, 2'b00};
    assign set_base  = LW'(((cur_waddr >> OB) & 32'(SETS - 1)) * 32'(WAYS));
    assign cur_tag   = TW'(cur_waddr >> (OB + SLOG));
    assign cur_word  = cur_waddr[OB-1:2];
    assign hit_line  = set_base + LW'(hit_way);
    assign fill_line = set_base + LW'(fway_reg);

    // A read or write crosses into the next word when offset plus length exceeds four.
    assign rcross = ({2'b00, pa_reg[1:0]} + {1'b0, clamp_len(plen_reg)}) > 4'd4;
    assign wlen   = clamp_len(len_reg);
    assign wcross = ({2'b00, addr_reg[1:0]} + {1'b0, wlen}) > 4'd4;

    // Write bytes and byte enables spread over the two words that an access can touch.
    assign w_sh_data = {32'd0, wdata_reg} << {addr_reg[1:0], 3'b000};
    assign w_sh_mask = {4'd0, len_mask(wlen)} << addr_reg[1:0];
    assign w_bytes   = w_sh_data[{widx_reg, 5'b00000} +: 32];
    assign w_mask    = w_sh_mask[{widx_reg, 2'b00} +: 4];

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            merged[8*b +: 8] = w_mask[b] ? w_bytes[8*b +: 8] : ram_q[8*b +: 8];
        end
    end

    // With every way of the set valid, the seed advances and picks the victim.
    assign seed_new   = seed_reg + cur_waddr[OB+1:2];
    assign victim_way = WB'(32'(seed_new));

    assign wr_more = !widx_reg && wcross;

    always_comb
    begin
        res_write             = '0;
        res_write.kind        = KIND_MEM_WR;
        res_write.mem_address = addr_reg;
        res_write.mem_length  = wlen;
        res_write.mem_data    = wdata_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        wdata_next     = wdata_reg;
        fdata_next     = fdata_reg;
        pa_next        = pa_reg;
        plen_next      = plen_reg;
        widx_next      = widx_reg;
        fwb_next       = fwb_reg;
        seed_next      = seed_reg;
        fpend_next     = fpend_reg;
        fcnt_next      = fcnt_reg;
        fway_next      = fway_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;

        tag_cmd        = '0;
        tag_wr_line    = fill_line;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = {hit_line, cur_word};
        ram_wdata      = merged;

        case (state_reg)
            S_CLEAR:
            begin
                // One valid bit cleared per cycle.
                tag_cmd.wr_en = 1'b1;
                tag_wr_line   = clr_reg;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == LW'(LINES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next   = req.action;
                    addr_next  = req.address;
                    len_next   = req.access_length;
                    wdata_next = req.write_data;
                    fdata_next = req.fill_data;
                    if (fpend_reg != (req.action == ACT_FILL))
                    begin
                        // A fill word with no fill open, or anything else during a fill.
                        res_next      = '0;
                        res_next.kind = KIND_ERROR;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        case (req.action)
                            ACT_READ:
                            begin
                                pa_next    = req.address;
                                plen_next  = req.access_length;
                                widx_next  = 1'b0;
                                state_next = S_LOOK;
                            end
                            ACT_WRITE:
                            begin
                                widx_next  = 1'b0;
                                state_next = S_LOOK;
                            end
                            ACT_FLUSH:
                            begin
                                clr_next   = '0;
                                state_next = S_CLEAR;
                            end
                            default:
                            begin
                                state_next = S_FILL;
                            end
                        endcase
                    end
                end
            end
            S_LOOK:
            begin
                tag_cmd.scan_start = 1'b1;
                state_next         = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.done)
                begin
                    if (stat.hit)
                    begin
                        ram_re     = 1'b1;
                        state_next = S_DDONE;
                    end
                    else if (act_reg == ACT_WRITE)
                    begin
                        // No write allocate: a missing word is left alone.
                        if (wr_more)
                        begin
                            widx_next  = 1'b1;
                            state_next = S_LOOK;
                        end
                        else
                        begin
                            res_next   = res_write;
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        // Read miss: claim a way and ask memory for the line.
                        fpend_next = 1'b1;
                        fcnt_next  = '0;
                        if (stat.free)
                        begin
                            fway_next = free_way;
                        end
                        else
                        begin
                            seed_next = seed_new;
                            fway_next = victim_way;
                        end
                        res_next             = '0;
                        res_next.kind        = KIND_FILL_REQ;
                        res_next.mem_address = cur_waddr & ~32'(LINE_BYTES - 1);
                        state_next           = S_EMIT;
                    end
                end
            end
            S_DDONE:
            begin
                if (act_reg == ACT_WRITE)
                begin
                    ram_we = 1'b1;
                    if (wr_more)
                    begin
                        widx_next  = 1'b1;
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        res_next   = res_write;
                        state_next = S_EMIT;
                    end
                end
                else if (!widx_reg)
                begin
                    fwb_next = ram_q;
                    if (rcross)
                    begin
                        widx_next  = 1'b1;
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        res_next           = '0;
                        res_next.kind      = KIND_DATA;
                        res_next.read_data = combine(ram_q, 32'd0, pa_reg[1:0]);
                        state_next         = S_EMIT;
                    end
                end
                else
                begin
                    widx_next          = 1'b0;
                    res_next           = '0;
                    res_next.kind      = KIND_DATA;
                    res_next.read_data = combine(fwb_reg, ram_q, pa_reg[1:0]);
                    state_next         = S_EMIT;
                end
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_addr  = {fill_line, fcnt_reg};
                ram_wdata = fdata_reg;
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_reg == WDB'(WPL - 1))
                begin
                    // Line complete: mark it valid and resume the read.
                    tag_cmd.wr_en    = 1'b1;
                    tag_cmd.wr_valid = 1'b1;
                    fpend_next       = 1'b0;
                    fcnt_next        = '0;
                    state_next       = S_FREAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREAD:
            begin
                ram_re     = 1'b1;
                ram_addr   = {fill_line, cur_word};
                state_next = S_DDONE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            act_reg       <= ACT_READ;
            widx_reg      <= 1'b0;
            seed_reg      <= '0;
            fpend_reg     <= 1'b0;
            fcnt_reg      <= '0;
            fway_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            widx_reg      <= widx_next;
            seed_reg      <= seed_next;
            fpend_reg     <= fpend_next;
            fcnt_reg      <= fcnt_next;
            fway_reg      <= fway_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        wdata_reg <= wdata_next;
        fdata_reg <= fdata_next;
        pa_reg    <= pa_next;
        plen_reg  <= plen_next;
        fwb_reg   <= fwb_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    sawtc_tag_scan #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .LINE_BYTES (LINE_BYTES)
    ) u_tag_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (tag_cmd),
        .set_base (set_base),
        .scan_tag (cur_tag),
        .wr_line  (tag_wr_line),
        .wr_tag   (cur_tag),
        .stat     (stat),
        .hit_way  (hit_way),
        .free_way (free_way)
    );

    sawtc_data_ram #(
        .DEPTH (LINES * WPL)
    ) u_data_ram (
        .clk   (clk),
        .re    (ram_re),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
endmodule

/* sim/sawtc_checker.sv */
// Transaction checker for the set-associative write-through cache: predicts and compares.
`timescale 1ns / 100ps
module sawtc_checker
    import sawtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  req_item_t req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_item_t rsp,
    output int        err_count,
    output int        outstanding,
    output logic      fill_busy
);

    // Predicted cache contents: 8 sets x 128 ways, 16 words per line.
    bit [31:0] line_word [0:16383];
    bit        line_ok   [0:1023];
    bit [22:0] line_tag  [0:1023];

    // Predicted sequencer state.
    bit [5:0]  seed;
    bit        busy;
    bit [3:0]  word_count;
    bit [6:0]  target_way;
    bit [31:0] read_addr;
    bit [2:0]  read_len;
    bit        second_word;
    bit [31:0] held_word;

    rsp_item_t expected_rsp [$];

    function automatic void queue_rsp(logic [1:0] kind, bit [31:0] rd, bit [31:0] ma,
                                      bit [2:0] ml, bit [31:0] md);
        rsp_item_t r;
        r.kind        = kind;
        r.read_data   = rd;
        r.mem_address = ma;
        r.mem_length  = ml;
        r.mem_data    = md;
        expected_rsp.push_back(r);
    endfunction

    function automatic bit [2:0] len_sat(bit [2:0] len);
        return (len > 3'd4) ? 3'd4 : len;
    endfunction

    function automatic bit [31:0] pick_bytes(bit [31:0] w0, bit [31:0] w1, bit [1:0] off);
        bit [63:0] v;
        v = {w1, w0} >> (8 * off);
        return v[31:0];
    endfunction

    function automatic bit lookup_word(bit [31:0] waddr, output bit [31:0] data);
        int ln;
        data = '0;
        for (int w = 0; w < 128; w++)
        begin
            ln = waddr[8:6] * 128 + w;
            if (line_ok[ln] && line_tag[ln] == waddr[31:9])
            begin
                data = line_word[ln * 16 + waddr[5:2]];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // A miss picks the first free way of the set; a full set uses the rolling seed.
    function automatic void begin_line_fill(bit [31:0] waddr);
        bit found;
        bit [6:0] way;
        found = 1'b0;
        way   = '0;
        for (int w = 0; w < 128 && !found; w++)
        begin
            if (!line_ok[waddr[8:6] * 128 + w])
            begin
                found = 1'b1;
                way   = w[6:0];
            end
        end
        if (!found)
        begin
            seed = waddr[7:2] + seed;
            way  = {1'b0, seed};
        end
        target_way = way;
        word_count = '0;
        busy       = 1'b1;
        queue_rsp(KIND_FILL_REQ, '0, {waddr[31:6], 6'd0}, '0, '0);
    endfunction

    // First word is known; either answer or go after the second word.
    function automatic void finish_first_word(bit [31:0] w0);
        bit [31:0] w1;
        bit [31:0] a1;
        w1 = '0;
        if (int'(read_addr[1:0]) + int'(len_sat(read_len)) > 4)
        begin
            a1 = {read_addr[31:2], 2'b00} + 32'd4;
            if (!lookup_word(a1, w1))
            begin
                held_word   = w0;
                second_word = 1'b1;
                begin_line_fill(a1);
                return;
            end
        end
        queue_rsp(KIND_DATA, pick_bytes(w0, w1, read_addr[1:0]), '0, '0, '0);
    endfunction

    function automatic void merge_word(bit [31:0] waddr, bit [31:0] data, bit [3:0] mask);
        int ln;
        for (int w = 0; w < 128; w++)
        begin
            ln = waddr[8:6] * 128 + w;
            if (line_ok[ln] && line_tag[ln] == waddr[31:9])
            begin
                for (int b = 0; b < 4; b++)
                begin
                    if (mask[b])
                    begin
                        line_word[ln * 16 + waddr[5:2]][8*b +: 8] = data[8*b +: 8];
                    end
                end
            end
        end
    endfunction

    function automatic void predict_cache(req_item_t it);
        bit [31:0] w0;
        bit [31:0] base;
        bit [31:0] waddr;
        bit [63:0] wide;
        bit [7:0]  mask;
        bit [2:0]  n;
        int        ln;
        base = {it.address[31:2], 2'b00};
        if (busy != (it.action == ACT_FILL))
        begin
            queue_rsp(KIND_ERROR, '0, '0, '0, '0);
            return;
        end
        case (it.action)
            ACT_READ:
            begin
                read_addr   = it.address;
                read_len    = it.access_length;
                second_word = 1'b0;
                if (!lookup_word(base, w0))
                    begin_line_fill(base);
                else
                    finish_first_word(w0);
            end
            ACT_WRITE:
            begin
                n    = len_sat(it.access_length);
                wide = {32'd0, it.write_data} << (8 * it.address[1:0]);
                mask = ((8'd1 << n) - 8'd1) << it.address[1:0];
                merge_word(base, wide[31:0], mask[3:0]);
                if (int'(it.address[1:0]) + int'(n) > 4)
                    merge_word(base + 32'd4, wide[63:32], mask[7:4]);
                queue_rsp(KIND_MEM_WR, '0, it.address, n, it.write_data);
            end
            ACT_FLUSH:
            begin
                for (int i = 0; i < 1024; i++)
                    line_ok[i] = 1'b0;
            end
            default:
            begin
                waddr = {read_addr[31:2], 2'b00} + (second_word ? 32'd4 : 32'd0);
                ln    = waddr[8:6] * 128 + target_way;
                line_word[ln * 16 + word_count] = it.fill_data;
                if (word_count != 4'd15)
                begin
                    word_count++;
                    return;
                end
                word_count   = '0;
                busy         = 1'b0;
                line_ok[ln]  = 1'b1;
                line_tag[ln] = waddr[31:9];
                w0 = line_word[ln * 16 + waddr[5:2]];
                if (!second_word)
                    finish_first_word(w0);
                else
                begin
                    second_word = 1'b0;
                    queue_rsp(KIND_DATA, pick_bytes(held_word, w0, read_addr[1:0]),
                              '0, '0, '0);
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 1024; i++)
                line_ok[i] = 1'b0;
            seed        = '0;
            busy        = 1'b0;
            word_count  = '0;
            target_way  = '0;
            read_addr   = '0;
            read_len    = '0;
            second_word = 1'b0;
            held_word   = '0;
            expected_rsp.delete();
            err_count   = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                predict_cache(req);
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected response transaction, kind %0d", rsp.kind);
                    err_count++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
                        err_count++;
                    end
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
                        err_count++;
                    end
                    if (rsp.mem_address !== want.mem_address)
                    begin
                        $error("mem_address: expected %h, got %h", want.mem_address,
                               rsp.mem_address);
                        err_count++;
                    end
                    if (rsp.mem_length !== want.mem_length)
                    begin
                        $error("mem_length: expected %0d, got %0d", want.mem_length,
                               rsp.mem_length);
                        err_count++;
                    end
                    if (rsp.mem_data !== want.mem_data)
                    begin
                        $error("mem_data: expected %h, got %h", want.mem_data, rsp.mem_data);
                        err_count++;
                    end
                end
            end
        end
        outstanding = expected_rsp.size();
        fill_busy   = busy;
    end

endmodule

/* sim/tb_set_assoc_write_through_cache.sv */
// Top-level testbench of the set-associative write-through cache: stimulus and verdict.
`timescale 1ns / 100ps
module tb_set_assoc_write_through_cache;
    import sawtc_pkg::*;

    // Flushes, the reset sweep, two-word lookups and response stalls all end well inside
    // STALL_LIMIT. Nothing legal should sit still that long.
    localparam int STALL_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    int   err_count;
    int   outstanding;
    logic fill_busy;

    int   items_sent;
    bit   no_idle;
    int   rsp_wait;
    int   rsp_draw;
    int   quiet_cycles;

    // Small set of tags that random traffic reuses so that reads and writes hit.
    bit [22:0] tag_pool [0:3];

    set_assoc_write_through_cache u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sawtc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .err_count   (err_count),
        .outstanding (outstanding),
        .fill_busy   (fill_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response side: after each accepted transaction the receiver holds ready low for a randomly
    // drawn stall that may be empty, except in the bursts where neither side idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_wait  <= 0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            if (no_idle)
            begin
                rsp_wait  <= 0;
                rsp_ready <= 1'b1;
            end
            else
            begin
                rsp_draw = $urandom_range(0, 7);
                rsp_wait  <= (rsp_draw > 0) ? rsp_draw - 1 : 0;
                rsp_ready <= (rsp_draw == 0);
            end
        end
        else if (rsp_wait > 0)
        begin
            rsp_wait  <= rsp_wait - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Watchdog: the run ends if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_set_assoc_write_through_cache: done, errors");
            $finish;
        end
    end

    // Present one transaction after a random gap and hold it until it is accepted.
    task automatic send_item(logic [1:0] action, bit [31:0] addr, bit [2:0] len,
                             bit [31:0] wdata);
        int gap;
        req_item_t it;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        it.action        = action;
        it.address       = addr;
        it.access_length = len;
        it.write_data    = wdata;
        it.fill_data     = $urandom;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        no_idle = ((items_sent / 100) % 4) == 3;
    endtask

    // Drop valid and wait until every predicted response has come back.
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // A read followed by whatever fill words the predicted misses call for.
    // Sometimes a stray transaction is slipped in while a fill is pending.
    task automatic read_access(bit [31:0] addr, bit [2:0] len, bit stray);
        send_item(ACT_READ, addr, len, $urandom);
        drain();
        if (stray && fill_busy)
        begin
            send_item(2'($urandom_range(0, 2)), $urandom, 3'($urandom_range(0, 7)), $urandom);
            drain();
        end
        while (fill_busy)
        begin
            repeat (16) send_item(ACT_FILL, $urandom, 3'($urandom_range(0, 7)), $urandom);
            drain();
        end
    endtask

    function automatic bit [31:0] pool_addr();
        return {tag_pool[$urandom_range(0, 3)], 3'($urandom_range(0, 7)),
                6'($urandom_range(0, 63))};
    endfunction

    initial
    begin
        int pick;
        bit [31:0] a;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        items_sent = 0;
        no_idle    = 1'b0;
        quiet_cycles = 0;
        for (int i = 0; i < 4; i++)
            tag_pool[i] = 23'($urandom);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        read_access(32'h0000_0000, 3'd1, 1'b0);      // cold miss
        read_access(32'h0000_0001, 3'd2, 1'b0);      // hit within one word
        read_access(32'h0000_003E, 3'd4, 1'b0);      // crosses into the next line
        send_item(ACT_WRITE, 32'h0000_003D, 3'd4, 32'hFFFF_FFFF); // spans two hit words
        send_item(ACT_WRITE, 32'h0000_0004, 3'd0, 32'hA5A5_A5A5); // zero length
        send_item(ACT_WRITE, 32'h0000_0008, 3'd7, 32'h0000_0000); // length above four
        send_item(ACT_WRITE, 32'h1234_5678, 3'd3, 32'h5A5A_5A5A); // miss, no allocate
        drain();
        read_access(32'h0000_003C, 3'd7, 1'b0);
        read_access(32'h0000_0005, 3'd0, 1'b0);
        read_access(32'hFFFF_FFFE, 3'd4, 1'b0);      // second word wraps to zero
        send_item(ACT_FILL, 32'h0, 3'd1, 32'h0);     // fill with nothing pending
        drain();
        read_access(32'h8000_0100, 3'd4, 1'b1);      // stray item during the fill
        send_item(ACT_FLUSH, 32'h0, 3'd0, 32'h0);
        drain();
        read_access(32'h0000_0000, 3'd4, 1'b0);      // misses again after flush

        // Load many ways of one set with distinct tags.
        for (int i = 0; i < 40; i++)
            read_access({23'(i * 37 + 5), 3'd3, 4'($urandom), 2'($urandom)},
                        3'($urandom_range(1, 4)), 1'b0);
        send_item(ACT_FLUSH, 32'h0, 3'd0, 32'h0);
        drain();

        // Random part.
        while (items_sent < 1600)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                read_access(pool_addr(), 3'($urandom_range(0, 7)),
                            $urandom_range(0, 19) == 0);
            else if (pick < 80)
                send_item(ACT_WRITE, pool_addr(), 3'($urandom_range(0, 7)), $urandom);
            else if (pick < 84)
            begin
                send_item(ACT_FILL, $urandom, 3'($urandom_range(0, 7)), $urandom);
                drain();
            end
            else if (pick < 86)
            begin
                send_item(ACT_FLUSH, $urandom, 3'($urandom_range(0, 7)), $urandom);
                drain();
            end
            else
            begin
                a = $urandom;
                if (pick < 93)
                    read_access(a, 3'($urandom_range(0, 7)), 1'b0);
                else
                    send_item(ACT_WRITE, a, 3'($urandom_range(0, 7)), $urandom);
            end
        end

        drain();
        repeat (300) @(posedge clk);
        if (err_count == 0 && outstanding == 0)
            $display("tb_set_assoc_write_through_cache: done, clean");
        else
            $display("tb_set_assoc_write_through_cache: done, errors");
        $finish;
    end

endmodule
